// ===== hw/rtl/rllh_pkg.sv =====
// ----------------------------------------------------------------------------
// rllh_pkg
// Types and constants shared by the latency histogram and its table cells.
// ----------------------------------------------------------------------------
package rllh_pkg;

  localparam int unsigned TAG_W = 16;
  localparam int unsigned TS_W  = 64;
  localparam int unsigned CNT_W = 64;
  localparam int unsigned NS_PER_US = 1000;

  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_NOP      = 2'd3;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_DROP    = 2'd1;
  localparam logic [1:0] STS_IGNORED = 2'd2;
  localparam logic [1:0] STS_RDDATA  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SWEEP,
    ST_DECIDE,
    ST_THRESH,
    ST_COUNT,
    ST_MEM_RD,
    ST_MEM_UPD,
    ST_RD_ADDR,
    ST_RD_OUT
  } state_t;

  // lookup token travelling down the row of cells
  typedef struct packed {
    logic            tok;
    logic            found;
    logic            claimed;
    logic [TS_W-1:0] start_time;
  } chain_t;

  // table update broadcast to all cells at the end of a sweep
  typedef struct packed {
    logic upd_hit;
    logic alloc;
    logic release_hit;
  } commit_t;

endpackage

// ===== hw/rtl/rllh_cell.sv =====
// ----------------------------------------------------------------------------
// rllh_cell
// One entry of the request table: holds tag and start time, joins the lookup
// token as it passes and applies the broadcast update.
// ----------------------------------------------------------------------------
module rllh_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rllh_pkg::chain_t             chain_i,
  output rllh_pkg::chain_t             chain_o,
  input  logic [rllh_pkg::TAG_W-1:0]   q_tag,
  input  logic [rllh_pkg::TS_W-1:0]    q_time,
  input  rllh_pkg::commit_t            commit_i,
  output logic                         hit_o
);

  logic                       valid_r, valid_nxt;
  logic [rllh_pkg::TAG_W-1:0] tag_r;
  logic [rllh_pkg::TS_W-1:0]  time_r;
  logic                       cand_r, cand_nxt;
  rllh_pkg::chain_t           chain_r, chain_nxt;

  assign hit_o   = valid_r && (tag_r == q_tag);
  assign chain_o = chain_r;

  always_comb begin
    chain_nxt.tok        = chain_i.tok;
    chain_nxt.found      = chain_i.found | (chain_i.tok & hit_o);
    chain_nxt.claimed    = chain_i.claimed | (chain_i.tok & ~valid_r);
    chain_nxt.start_time = (chain_i.tok && hit_o) ? time_r : chain_i.start_time;
    // first free entry along the row
    cand_nxt = chain_i.tok ? (!valid_r && !chain_i.claimed) : cand_r;
    valid_nxt = valid_r;
    if (commit_i.release_hit && hit_o) begin
      valid_nxt = 1'b0;
    end else if (commit_i.alloc && cand_r) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
      chain_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_i.upd_hit && hit_o) begin
      time_r <= q_time;
    end else if (commit_i.alloc && cand_r) begin
      tag_r  <= q_tag;
      time_r <= q_time;
    end
  end

endmodule

// ===== hw/rtl/request_latency_log2_histogram.sv =====
// ----------------------------------------------------------------------------
// request_latency_log2_histogram
// Tracks outstanding request tags and bins completion latencies (us) into a
// power-of-two histogram of 64-bit counters.
// ----------------------------------------------------------------------------
// read items pass RD_ADDR and RD_OUT; unused-code items are answered from idle
// start and complete items pass LAUNCH, SWEEP and DECIDE while the token walks
//   the row of cells; a binned completion adds THRESH, COUNT, MEM_RD, MEM_UPD
// one item at a time: busy is high from accept to result strobe (not for NOP)
// synchronous reset empties the table and zeroes every histogram bin
module request_latency_log2_histogram #(
  parameter int unsigned HIST_BINS     = 32,
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_request_id,
  input  logic [63:0] in_timestamp_ns,
  input  logic [4:0]  in_bin_select,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_bin_index,
  output logic [63:0] out_bin_value
);

  localparam int unsigned BIN_W = $clog2(HIST_BINS);
  localparam int unsigned THR_W = rllh_pkg::TS_W + 10;

  rllh_pkg::state_t state_r, state_nxt;

  logic [1:0]                 q_op_r;
  logic [rllh_pkg::TAG_W-1:0] q_tag_r;
  logic [rllh_pkg::TS_W-1:0]  q_time_r;
  logic [4:0]                 q_sel_r;

  logic                       found_r, claimed_r;
  logic [rllh_pkg::TS_W-1:0]  st_time_r;
  logic [rllh_pkg::TS_W-1:0]  delta_r;
  logic [HIST_BINS-1:0]       ge_r, ge_nxt;
  logic [BIN_W-1:0]           bin_r;

  logic                       accept;
  logic                       time_ok;
  logic [6:0]                 sel_ext, bin_ext;
  logic                       sel_oob;

  rllh_pkg::chain_t           chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0]   hit_vec;
  rllh_pkg::commit_t          commit;

  logic [rllh_pkg::CNT_W-1:0] bin_mem [HIST_BINS];
  logic [HIST_BINS-1:0]       bin_vld_r;
  logic [BIN_W-1:0]           mem_ra;
  logic                       mem_we;
  logic [rllh_pkg::CNT_W-1:0] mem_wd;
  logic [rllh_pkg::CNT_W-1:0] rd_data_r;
  logic                       rd_vld_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  logic [4:0]                 out_bin_index_r, out_bin_index_nxt;
  logic [63:0]                out_bin_value_r, out_bin_value_nxt;

  assign accept  = start && !busy;
  assign busy    = (state_r != rllh_pkg::ST_IDLE);
  assign time_ok = (q_time_r >= st_time_r);
  assign sel_ext = {2'b00, q_sel_r};
  assign sel_oob = (sel_ext >= 7'(HIST_BINS));
  assign bin_ext = 7'(bin_r);

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bin_index = out_bin_index_r;
  assign out_bin_value = out_bin_value_r;

  // row of table cells
  always_comb begin
    chain[0]     = '0;
    chain[0].tok = (state_r == rllh_pkg::ST_LAUNCH);
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    rllh_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .chain_i  (chain[i]),
      .chain_o  (chain[i+1]),
      .q_tag    (q_tag_r),
      .q_time   (q_time_r),
      .commit_i (commit),
      .hit_o    (hit_vec[i])
    );
  end

  // us >= 2^k exactly when ns >= 1000 * 2^k
  always_comb begin
    ge_nxt = '0;
    for (int k = 1; k < HIST_BINS; k++) begin
      ge_nxt[k] = ({10'd0, delta_r} >= (THR_W'(rllh_pkg::NS_PER_US) << k));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rllh_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == rllh_pkg::OP_START ||
              in_operation == rllh_pkg::OP_COMPLETE) begin
            state_nxt = rllh_pkg::ST_LAUNCH;
          end else if (in_operation == rllh_pkg::OP_READ) begin
            state_nxt = rllh_pkg::ST_RD_ADDR;
          end
        end
      end
      rllh_pkg::ST_LAUNCH:  state_nxt = rllh_pkg::ST_SWEEP;
      rllh_pkg::ST_SWEEP: begin
        if (chain[TABLE_ENTRIES].tok) begin
          state_nxt = rllh_pkg::ST_DECIDE;
        end
      end
      rllh_pkg::ST_DECIDE: begin
        if (q_op_r == rllh_pkg::OP_COMPLETE && found_r && time_ok) begin
          state_nxt = rllh_pkg::ST_THRESH;
        end else begin
          state_nxt = rllh_pkg::ST_IDLE;
        end
      end
      rllh_pkg::ST_THRESH:  state_nxt = rllh_pkg::ST_COUNT;
      rllh_pkg::ST_COUNT:   state_nxt = rllh_pkg::ST_MEM_RD;
      rllh_pkg::ST_MEM_RD:  state_nxt = rllh_pkg::ST_MEM_UPD;
      rllh_pkg::ST_MEM_UPD: state_nxt = rllh_pkg::ST_IDLE;
      rllh_pkg::ST_RD_ADDR: state_nxt = rllh_pkg::ST_RD_OUT;
      rllh_pkg::ST_RD_OUT:  state_nxt = rllh_pkg::ST_IDLE;
      default:              state_nxt = rllh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt     = 1'b0;
    out_status_nxt    = rllh_pkg::STS_DONE;
    out_bin_index_nxt = '0;
    out_bin_value_nxt = '0;
    commit            = '0;
    mem_we            = 1'b0;
    mem_wd            = rd_vld_r ? (rd_data_r + 64'd1) : 64'd1;
    mem_ra            = bin_r;
    unique case (state_r)
      rllh_pkg::ST_IDLE: begin
        if (accept && in_operation == rllh_pkg::OP_NOP) begin
          out_valid_nxt = 1'b1;
        end
      end
      rllh_pkg::ST_DECIDE: begin
        if (q_op_r == rllh_pkg::OP_START) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            commit.upd_hit = 1'b1;
          end else if (claimed_r) begin
            commit.alloc = 1'b1;
          end else begin
            out_status_nxt = rllh_pkg::STS_DROP;
          end
        end else if (!found_r || !time_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rllh_pkg::STS_IGNORED;
        end else begin
          commit.release_hit = 1'b1;
        end
      end
      rllh_pkg::ST_MEM_UPD: begin
        mem_we            = 1'b1;
        out_valid_nxt     = 1'b1;
        out_bin_index_nxt = bin_ext[4:0];
        out_bin_value_nxt = mem_wd;
      end
      rllh_pkg::ST_RD_ADDR: begin
        mem_ra = sel_oob ? '0 : sel_ext[BIN_W-1:0];
      end
      rllh_pkg::ST_RD_OUT: begin
        out_valid_nxt     = 1'b1;
        out_status_nxt    = rllh_pkg::STS_RDDATA;
        out_bin_index_nxt = q_sel_r;
        out_bin_value_nxt = (sel_oob || !rd_vld_r) ? 64'd0 : rd_data_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rllh_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      bin_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        bin_vld_r[bin_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r    <= out_status_nxt;
    out_bin_index_r <= out_bin_index_nxt;
    out_bin_value_r <= out_bin_value_nxt;
    if (accept) begin
      q_op_r   <= in_operation;
      q_tag_r  <= in_request_id;
      q_time_r <= in_timestamp_ns;
      q_sel_r  <= in_bin_select;
    end
    if (state_r == rllh_pkg::ST_SWEEP && chain[TABLE_ENTRIES].tok) begin
      found_r   <= chain[TABLE_ENTRIES].found;
      claimed_r <= chain[TABLE_ENTRIES].claimed;
      st_time_r <= chain[TABLE_ENTRIES].start_time;
    end
    delta_r <= q_time_r - st_time_r;
    ge_r    <= ge_nxt;
    bin_r   <= BIN_W'($countones(ge_r));
  end

  // histogram counters
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[bin_r] <= mem_wd;
    end
    rd_data_r <= bin_mem[mem_ra];
    rd_vld_r  <= bin_vld_r[mem_ra];
  end

  a_unique_tags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rllh_pkg::ST_DECIDE) |-> $onehot0(hit_vec))
    else $error("tag held by more than one table entry");

  a_no_stray_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rllh_pkg::ST_IDLE) |-> !chain[TABLE_ENTRIES].tok)
    else $error("lookup token left the row while idle");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == rllh_pkg::STS_DROP) |->
      ($past(!claimed_r) && $past(!found_r)))
    else $error("start dropped although a free entry existed");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rllh_pkg::ST_MEM_UPD) |=> (out_valid_r && state_r == rllh_pkg::ST_IDLE))
    else $error("binned completion gave no result");

endmodule

// ===== tb/tb_request_latency_log2_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_request_latency_log2_histogram
// Drives start, complete, read and unused-code items into the latency histogram,
// predicts each result from a local model of the tag table and bins, and checks them.
// ----------------------------------------------------------------------------
module tb_request_latency_log2_histogram;

  localparam int NBINS   = 32;
  localparam int NSLOTS  = 64;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  bin_index;
    logic [63:0] bin_value;
  } hist_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [15:0] in_request_id;
  logic [63:0] in_timestamp_ns;
  logic [4:0]  in_bin_select;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [4:0]  out_bin_index;
  logic [63:0] out_bin_value;

  request_latency_log2_histogram u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_id(in_request_id),
    .in_timestamp_ns(in_timestamp_ns), .in_bin_select(in_bin_select),
    .out_valid(out_valid), .out_status(out_status),
    .out_bin_index(out_bin_index), .out_bin_value(out_bin_value)
  );

  // model state
  bit          slot_used [NSLOTS];
  logic [15:0] slot_tag  [NSLOTS];
  logic [63:0] slot_time [NSLOTS];
  logic [63:0] bin_tally [NBINS];

  hist_result_t pending_results[$];
  int unsigned  err_count;
  int           gap_max;
  logic [63:0]  clock_ns;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("request_latency_log2_histogram regression: fail");
    $finish;
  end

  function automatic int find_slot(logic [15:0] tag);
    for (int i = 0; i < NSLOTS; i++) begin
      if (slot_used[i] && slot_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  function automatic hist_result_t predict_latency(logic [1:0] op, logic [15:0] tag,
                                                   logic [63:0] now, logic [4:0] sel);
    hist_result_t r;
    int          s;
    logic [63:0] us;
    int          b;
    r = '{rllh_pkg::STS_DONE, 5'd0, 64'd0};
    case (op)
      rllh_pkg::OP_START: begin
        s = find_slot(tag);
        if (s < 0) begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (!slot_used[i]) begin
              s = i;
              break;
            end
          end
        end
        if (s < 0) r.status = rllh_pkg::STS_DROP;
        else begin
          slot_used[s] = 1'b1;
          slot_tag[s]  = tag;
          slot_time[s] = now;
        end
      end
      rllh_pkg::OP_COMPLETE: begin
        s = find_slot(tag);
        if (s < 0 || now < slot_time[s]) r.status = rllh_pkg::STS_IGNORED;
        else begin
          slot_used[s] = 1'b0;
          us = (now - slot_time[s]) / 64'd1000;
          b = 0;
          for (int k = 63; k > 0; k--) begin
            if (us[k]) begin
              b = k;
              break;
            end
          end
          if (b > NBINS - 1) b = NBINS - 1;
          bin_tally[b] = bin_tally[b] + 64'd1;
          r.bin_index = b[4:0];
          r.bin_value = bin_tally[b];
        end
      end
      rllh_pkg::OP_READ: begin
        r.status    = rllh_pkg::STS_RDDATA;
        r.bin_index = sel;
        r.bin_value = (sel < NBINS) ? bin_tally[sel] : 64'd0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // checks every strobed result against the oldest prediction
  always @(posedge clk) begin
    hist_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: status %0d", out_status);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          err_count++;
        end
        if (out_bin_index !== e.bin_index) begin
          $error("bin_index: expected %0d actual %0d", e.bin_index, out_bin_index);
          err_count++;
        end
        if (out_bin_value !== e.bin_value) begin
          $error("bin_value: expected %0d actual %0d", e.bin_value, out_bin_value);
          err_count++;
        end
      end
    end
  end

  // start stays high across back-to-back items; a random gap or wait_drained drops it
  task automatic send_item(logic [1:0] op, logic [15:0] tag, logic [63:0] now,
                           logic [4:0] sel);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      start           <= 1'b0;
      in_operation    <= $urandom();
      in_request_id   <= $urandom();
      in_timestamp_ns <= {$urandom(), $urandom()};
      in_bin_select   <= $urandom();
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_request_id   <= tag;
    in_timestamp_ns <= now;
    in_bin_select   <= sel;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_latency(op, tag, now, sel));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_item(rllh_pkg::OP_READ, 16'h0, 64'd0, 5'd0);
    send_item(rllh_pkg::OP_COMPLETE, 16'hFFFF, 64'd5000, 5'd0);          // absent tag
    send_item(rllh_pkg::OP_START, 16'h0000, 64'd0, 5'd31);
    send_item(rllh_pkg::OP_COMPLETE, 16'h0000, 64'd999, 5'd0);            // zero us
    send_item(rllh_pkg::OP_START, 16'hFFFF, 64'd10_000, 5'd0);
    send_item(rllh_pkg::OP_START, 16'hFFFF, 64'd20_000, 5'd0);            // overwrite
    send_item(rllh_pkg::OP_COMPLETE, 16'hFFFF, 64'd19_000, 5'd0);         // backwards
    send_item(rllh_pkg::OP_COMPLETE, 16'hFFFF, 64'd22_000, 5'd0);
    send_item(rllh_pkg::OP_START, 16'h1234, 64'd0, 5'd0);
    send_item(rllh_pkg::OP_COMPLETE, 16'h1234, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0); // saturate
    send_item(rllh_pkg::OP_START, 16'h5555, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
    send_item(rllh_pkg::OP_COMPLETE, 16'h5555, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
    send_item(rllh_pkg::OP_NOP, 16'hABCD, 64'hAAAA_5555_AAAA_5555, 5'd17);
    send_item(rllh_pkg::OP_READ, 16'h0, 64'd0, 5'd31);
    send_item(rllh_pkg::OP_READ, 16'h0, 64'd0, 5'd1);
    send_item(rllh_pkg::OP_READ, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NSLOTS + 2; i++)
      send_item(rllh_pkg::OP_START, 16'h8000 + i[15:0], clock_ns + i * 700, 5'd0);
    wait_drained();   // sender holds off until the table is settled
    for (int i = 0; i < NSLOTS + 1; i++)
      send_item(rllh_pkg::OP_COMPLETE, 16'h8000 + i[15:0],
                clock_ns + 64'd50_000 * (i + 1), 5'd0);
    clock_ns = clock_ns + 64'd10_000_000;
  endtask

  task automatic test_random_traffic(int n);
    logic [1:0]  op;
    logic [15:0] tag;
    logic [63:0] now;
    int          sh;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      tag = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 47));
      sh  = $urandom_range(0, 40);
      clock_ns = clock_ns + (64'($urandom()) >> (31 - (sh % 32)));
      now = clock_ns;
      case ($urandom_range(0, 19))
        0:  now = {$urandom(), $urandom()};
        1:  now = clock_ns - $urandom_range(0, 5000);
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = rllh_pkg::OP_START;
        4, 5, 6, 7: op = rllh_pkg::OP_COMPLETE;
        8:          op = rllh_pkg::OP_READ;
        default:    op = ($urandom_range(0, 1) != 0) ? rllh_pkg::OP_READ : rllh_pkg::OP_NOP;
      endcase
      send_item(op, tag, now, 5'($urandom()));
    end
  endtask

  task automatic test_read_all_bins();
    for (int b = 0; b < NBINS; b++)
      send_item(rllh_pkg::OP_READ, 16'($urandom()), 64'd0, b[4:0]);
  endtask

  initial begin
    err_count = 0;
    gap_max   = 0;
    clock_ns  = 64'd1_000_000;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_operation    = rllh_pkg::OP_NOP;
    in_request_id   = '0;
    in_timestamp_ns = '0;
    in_bin_select   = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_tag[i]  = '0;
      slot_time[i] = '0;
    end
    for (int i = 0; i < NBINS; i++) bin_tally[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    gap_max = 19;
    test_table_full();
    test_random_traffic(1450);
    test_read_all_bins();

    wait_drained();
    repeat (200) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("request_latency_log2_histogram regression: pass");
    else
      $display("request_latency_log2_histogram regression: fail");
    $finish;
  end

endmodule
